// ----- hw/rtl/iirl_pkg.sv -----
// Types, codes and elaboration helpers for the indexed insert/remove list.
// No dependencies; used by every module of the block.
package iirl_pkg;

    localparam int unsigned DEF_CAPACITY = 64;
    localparam int unsigned TREE_FANIN   = 8;

    typedef logic signed [31:0] t_word;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_APPEND = 3'd3,
        OP_POP    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  position;
        t_word       word_in;
    } t_req;

    typedef struct packed {
        t_word       word_out;
        logic [1:0]  status;
        logic [6:0]  count;
    } t_rsp;

    // Per-cell control for one cycle
    typedef struct packed {
        logic load;        // take the request word
        logic take_left;   // shift up: take lower neighbor
        logic take_right;  // shift down: take upper neighbor
        logic rd_sel;      // drive entry onto the read-out tree
    } t_cell_ctl;

    // Nodes at tree level lvl (level 0 = leaves), fan-in of eight
    function automatic int unsigned f_nodes_at(input int unsigned n, input int unsigned lvl);
        int unsigned m;
        m = n;
        for (int unsigned s = 0; s < 16; s++) begin
            if (s < lvl) begin
                m = (m + TREE_FANIN - 1) >> 3;
            end
        end
        return m;
    endfunction

    // Registered levels needed to reduce n leaves to one word
    function automatic int unsigned f_levels(input int unsigned n);
        int unsigned m;
        int unsigned l;
        m = n;
        l = 0;
        for (int unsigned s = 0; s < 16; s++) begin
            if (m > 1) begin
                m = (m + TREE_FANIN - 1) >> 3;
                l = l + 1;
            end
        end
        return (l == 0) ? 1 : l;
    endfunction

    // Flat offset of the first node of level lvl (levels counted from 1)
    function automatic int unsigned f_offset(input int unsigned n, input int unsigned lvl);
        int unsigned acc;
        acc = 0;
        for (int unsigned s = 1; s < 16; s++) begin
            if (s < lvl) begin
                acc = acc + f_nodes_at(n, s);
            end
        end
        return acc;
    endfunction

endpackage

// ----- hw/rtl/iirl_cell.sv -----
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on iirl_pkg.
module iirl_cell
    import iirl_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_left,
    input  t_word     i_right,
    input  t_word     i_word,
    output t_word     o_entry,
    output t_word     o_rd
);

    t_word r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_word;
        end else if (i_ctl.take_left) begin
            r_entry <= i_left;
        end else if (i_ctl.take_right) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;
    assign o_rd    = i_ctl.rd_sel ? r_entry : '0;

endmodule

// ----- hw/rtl/iirl_or_tree.sv -----
// Registered OR-reduction tree (fan-in 8) that collects the one selected cell word.
// Depends on iirl_pkg.
module iirl_or_tree
    import iirl_pkg::*;
#(
    parameter int unsigned NLEAF = DEF_CAPACITY
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_leaf [NLEAF],
    output logic  o_vld,
    output t_word o_word,
    output logic  o_busy
);

    localparam int unsigned LEVELS = f_levels(NLEAF);
    localparam int unsigned TOTAL  = f_offset(NLEAF, LEVELS + 1);

    t_word       r_node [TOTAL];
    logic [LEVELS-1:0] r_vld;

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int unsigned NPREV = f_nodes_at(NLEAF, l - 1);
        localparam int unsigned NCUR  = f_nodes_at(NLEAF, l);
        localparam int unsigned OFFC  = f_offset(NLEAF, l);
        localparam int unsigned OFFP  = (l > 1) ? f_offset(NLEAF, l - 1) : 0;
        for (genvar k = 0; k < NCUR; k++) begin : g_node
            localparam int unsigned NCH =
                (NPREV - TREE_FANIN * k > TREE_FANIN) ? TREE_FANIN : NPREV - TREE_FANIN * k;
            t_word n_node;
            if (l == 1) begin : g_leafin
                always_comb begin
                    n_node = '0;
                    for (int unsigned c = 0; c < NCH; c++) begin
                        n_node = n_node | i_leaf[TREE_FANIN * k + c];
                    end
                end
            end else begin : g_nodein
                always_comb begin
                    n_node = '0;
                    for (int unsigned c = 0; c < NCH; c++) begin
                        n_node = n_node | r_node[OFFP + TREE_FANIN * k + c];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[OFFC + k] <= n_node;
            end
        end
    end

    // valid marker travels with the data through the levels
    if (LEVELS == 1) begin : g_vld_one
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= '0;
            end else begin
                r_vld <= i_start;
            end
        end
    end else begin : g_vld_chain
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= '0;
            end else begin
                r_vld <= {r_vld[LEVELS-2:0], i_start};
            end
        end
    end

    assign o_vld  = r_vld[LEVELS-1];
    assign o_word = r_node[TOTAL-1];
    assign o_busy = |r_vld;

endmodule

// ----- hw/rtl/indexed_insert_remove_list_core.sv -----
// Top level of the indexed insert/remove list: control decode, cell chain, read-out tree.
// Depends on iirl_pkg, iirl_cell, iirl_or_tree.
//
// Ordered list of up to CAPACITY signed 32-bit words, packed from position 0.
// A request is taken when start is high and busy is low; it may insert, remove,
// read, append or pop. All entries sit in a chain of cells, one word each, so
// an insert or remove shifts the whole tail in the cycle the request is taken.
// The word that is read, removed or popped comes back through a registered
// OR tree of fan-in 8. Busy stays high from the accepted request through the
// cycle of its response, so no new request is taken before it. The response
// (word, status, count after the request) is presented for one cycle with
// o_done; there is no back-pressure, so the receiver must take it in that
// cycle. Status is ok, position out of range, list full, or list empty. Count
// reports the low 7 bits of the entry count. Entries hold no reset value;
// positions at or above the count are never read out. Unused operation codes
// return ok with a zero word and leave the list as it is.
module indexed_insert_remove_list_core
    import iirl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output t_rsp o_rsp,
    output logic o_done
);

    localparam int unsigned CW     = $clog2(CAPACITY + 1);
    localparam int unsigned W      = (CW > 7) ? CW : 7;
    localparam int unsigned LEVELS = f_levels(CAPACITY);

    logic          w_acc;
    logic          w_busy;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_status       r_status;
    t_status       n_status;

    logic [W-1:0]  w_pos;
    logic [W-1:0]  w_cnt;
    logic [W-1:0]  w_rd_idx;
    logic          w_full;
    logic          w_ins_ok;
    logic          w_rem_ok;
    logic          w_app_ok;
    logic          w_rd_en;

    t_word         w_entry [CAPACITY];
    t_word         w_leaf  [CAPACITY];
    t_word         w_tree_word;
    logic          w_tree_vld;

    assign w_acc  = start && !w_busy;
    assign busy   = w_busy;

    assign w_pos  = W'(i_req.position);
    assign w_cnt  = W'(r_count);
    assign w_full = (w_cnt == W'(CAPACITY));

    // ---- request decode ----
    always_comb begin
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_app_ok = 1'b0;
        w_rd_en  = 1'b0;
        w_rd_idx = w_pos;
        n_status = ST_OK;
        n_count  = r_count;
        case (i_req.operation)
            OP_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_rem_ok = 1'b1;
                    w_rd_en  = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            OP_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_app_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_cnt - W'(1);
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // ---- count and status, held for the response ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
        end
    end

    // ---- cell chain ----
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_word     w_left;
        t_word     w_right;

        // tail shifts up for insert, down for remove; append loads at the end
        assign w_ctl.load       = w_acc && ((w_ins_ok && (W'(i) == w_pos)) ||
                                            (w_app_ok && (W'(i) == w_cnt)));
        assign w_ctl.take_left  = w_acc && w_ins_ok && (W'(i) > w_pos);
        assign w_ctl.take_right = w_acc && w_rem_ok && (W'(i) >= w_pos);
        assign w_ctl.rd_sel     = w_acc && w_rd_en && (W'(i) == w_rd_idx);

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[i+1];
        end

        iirl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_word  (i_req.word_in),
            .o_entry (w_entry[i]),
            .o_rd    (w_leaf[i])
        );
    end

    // ---- read-out tree; leaves are pre-shift values at the accept edge ----
    iirl_or_tree #(
        .NLEAF (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_leaf  (w_leaf),
        .o_vld   (w_tree_vld),
        .o_word  (w_tree_word),
        .o_busy  (w_busy)
    );

    assign o_done         = w_tree_vld;
    assign o_rsp.word_out = w_tree_word;
    assign o_rsp.status   = r_status;
    assign o_rsp.count    = r_count[6:0];

    // ---- checks ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W'(r_count) <= W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("count changed without a request");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LEVELS o_done)
        else $error("response missing after fixed latency");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("still busy after response");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> busy)
        else $error("busy not raised after accept");

endmodule

// ----- dv/indexed_insert_remove_list_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for indexed_insert_remove_list_core: random and directed list requests
// checked against an in-bench list predictor. Depends on iirl_pkg and the core RTL.
module indexed_insert_remove_list_core_tb;
    import iirl_pkg::*;

    localparam int unsigned CAPACITY   = DEF_CAPACITY;
    localparam int          RAND_REQS  = 1376;
    localparam int          QUIET_TAIL = 200;   // last requests go back to back

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    t_rsp o_rsp;
    logic o_done;

    indexed_insert_remove_list_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .o_done (o_done)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven, and outcomes waiting for o_done
    t_req queued_reqs[$];
    t_rsp pending_outcomes[$];

    // Shadow of the list as the core should hold it
    t_word list_words[CAPACITY];
    int    list_len;

    // Entry count as seen by the stimulus generator, to aim positions
    int    gen_len;

    int    fail_count;
    int    total_reqs;
    int    taken_reqs;
    int    idle_left;
    bit    req_taken;

    // Apply one request to the shadow list and return what the core must answer
    function automatic t_rsp list_outcome(input t_req req);
        t_rsp rsp;
        int   pos;
        rsp = '0;
        pos = int'(req.position);
        case (req.operation)
            OP_INSERT: begin
                if (pos > list_len) begin
                    rsp.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;   // range check wins over full
                end else begin
                    for (int i = list_len; i > pos; i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos] = req.word_in;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (pos >= list_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.word_out = list_words[pos];
                    for (int i = pos; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            end
            OP_READ: begin
                if (pos >= list_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.word_out = list_words[pos];
                end
            end
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_words[list_len] = req.word_in;
                    list_len++;
                end
            end
            OP_POP: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    list_len--;
                    rsp.word_out = list_words[list_len];
                end
            end
            default: begin
                // unused codes: ok, zero word, list untouched
            end
        endcase
        rsp.count = 7'(list_len);
        return rsp;
    endfunction

    // Queue a request and track the count it leaves behind
    task automatic queue_req(input logic [2:0] op, input logic [6:0] pos, input t_word word);
        t_req req;
        req.operation = op;
        req.position  = pos;
        req.word_in   = word;
        queued_reqs.push_back(req);
        case (op)
            OP_INSERT: if (int'(pos) <= gen_len && gen_len < CAPACITY) gen_len++;
            OP_REMOVE: if (int'(pos) < gen_len) gen_len--;
            OP_APPEND: if (gen_len < CAPACITY) gen_len++;
            OP_POP:    if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endtask

    // Words lean on the sign and magnitude extremes now and then
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Mostly legal positions, with the boundary and stray values mixed in
    function automatic logic [6:0] rand_position(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 7'($urandom_range(0, 127));
        if (r < 16) return 7'(gen_len);
        if (op == OP_INSERT) return 7'($urandom_range(0, gen_len));
        if (gen_len == 0) return 7'd0;
        return 7'($urandom_range(0, gen_len - 1));
    endfunction

    // Driver: new request on the falling edge, held until the core takes it
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !req_taken) begin
                // core still busy, keep the request up
            end else if (idle_left > 0) begin
                start <= 1'b0;
                idle_left--;
            end else if (queued_reqs.size() == 0) begin
                start <= 1'b0;
            end else if (taken_reqs < total_reqs - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                // idle burst; this cycle is its first and idle_left holds the rest
                start <= 1'b0;
                idle_left = $urandom_range(0, 7);
            end else begin
                start <= 1'b1;
                i_req <= queued_reqs[0];
            end
            req_taken = 1'b0;
        end
    end

    // Monitor: check responses, then log any request taken this edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t unexpected response: word %0d status %0d count %0d",
                             $time, o_rsp.word_out, o_rsp.status, o_rsp.count);
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_rsp.word_out !== want.word_out) begin
                        $display("%0t word_out mismatch: expected %0d actual %0d",
                                 $time, want.word_out, o_rsp.word_out);
                        fail_count++;
                    end
                    if (o_rsp.status !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, o_rsp.status);
                        fail_count++;
                    end
                    if (o_rsp.count !== want.count) begin
                        $display("%0t count mismatch: expected %0d actual %0d",
                                 $time, want.count, o_rsp.count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                pending_outcomes.push_back(list_outcome(i_req));
                void'(queued_reqs.pop_front());
                taken_reqs++;
                req_taken = 1'b1;
            end
        end
    end

    initial begin
        logic [2:0] op;
        int         mode;
        int         r;

        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        list_len   = 0;
        gen_len    = 0;
        fail_count = 0;
        taken_reqs = 0;
        idle_left  = 0;
        req_taken  = 1'b0;

        // Directed: empty-list errors first
        queue_req(OP_POP,    7'd0,   32'sd0);
        queue_req(OP_READ,   7'd0,   32'sd0);
        queue_req(OP_REMOVE, 7'd0,   32'sd0);
        queue_req(OP_INSERT, 7'd1,   32'sd9);          // past the end
        // Build a short list through every insert flavor
        queue_req(OP_INSERT, 7'd0,   32'sh7fff_ffff);
        queue_req(OP_APPEND, 7'd127, 32'sh8000_0000);
        queue_req(OP_INSERT, 7'd1,   -32'sd1);          // middle
        queue_req(OP_INSERT, 7'd3,   32'sd0);          // at count, acts as append
        queue_req(OP_INSERT, 7'd127, 32'sd5);          // far out of range
        queue_req(OP_READ,   7'd0,   32'sd0);
        queue_req(OP_READ,   7'd1,   32'sd0);
        queue_req(OP_READ,   7'd2,   32'sd0);
        queue_req(OP_READ,   7'd3,   32'sd0);
        queue_req(OP_READ,   7'd4,   32'sd0);          // equal to count
        queue_req(OP_READ,   7'd127, -32'sd1);
        queue_req(OP_REMOVE, 7'd1,   32'sd0);
        queue_req(OP_REMOVE, 7'd64,  32'sd0);
        // Unused codes leave the list alone
        queue_req(3'd5,      7'd127, -32'sd1);
        queue_req(3'd6,      7'd0,   32'sh5555_5555);
        queue_req(3'd7,      7'd64,  32'shaaaa_aaaa);
        // Drain back to empty
        queue_req(OP_POP,    7'd0,   32'sd0);
        queue_req(OP_POP,    7'd0,   32'sd0);
        queue_req(OP_REMOVE, 7'd0,   32'sd0);
        queue_req(OP_POP,    7'd0,   32'sd0);

        // Random: phases that fill to capacity, churn, then drain
        for (int n = 0; n < RAND_REQS; n++) begin
            mode = (n / 140) % 3;   // 0 grow, 1 mixed, 2 shrink
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = 3'($urandom_range(5, 7));
            end else if (mode == 0) begin
                op = (r < 45) ? OP_APPEND : (r < 85) ? OP_INSERT :
                     (r < 93) ? OP_READ   : (r < 97) ? OP_REMOVE : OP_POP;
            end else if (mode == 2) begin
                op = (r < 40) ? OP_REMOVE : (r < 75) ? OP_POP :
                     (r < 88) ? OP_READ   : (r < 94) ? OP_INSERT : OP_APPEND;
            end else begin
                op = (r < 22) ? OP_INSERT : (r < 42) ? OP_REMOVE :
                     (r < 62) ? OP_READ   : (r < 82) ? OP_APPEND : OP_POP;
            end
            queue_req(op, rand_position(op), rand_word());
        end
        total_reqs = queued_reqs.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (queued_reqs.size() == 0);
        wait (pending_outcomes.size() == 0);
        // leave room for a stray response after the last expected one
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
